>>> hw/rtl/blal_pkg.sv
// shared types and constants for the bounded array list engine
// request and result beats, operation codes, sequencer states
// no dependencies
`default_nettype none

package blal_pkg;

  typedef enum logic [3:0] {
    FN_APPEND = 4'd0,
    FN_INSERT = 4'd1,
    FN_PEEK   = 4'd2,
    FN_FIND   = 4'd3,
    FN_RMKEY  = 4'd4,
    FN_COUNT  = 4'd5,
    FN_RMIDX  = 4'd6,
    FN_MAX    = 4'd7,
    FN_MIN    = 4'd8
  } blal_func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UP,
    ST_DN,
    ST_PUT,
    ST_FIN
  } blal_state_t;

  localparam logic [6:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] value;
    logic [6:0]         index;
  } blal_req_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] item_value;
    logic [5:0]         position;
    logic [6:0]         match_count;
    logic [6:0]         item_count;
    logic               is_full;
    logic               is_empty;
  } blal_rsp_t;

  typedef struct packed {
    logic eq;
    logic gt;
    logic lt;
  } blal_cmp_t;

endpackage

`default_nettype wire

>>> hw/rtl/blal_mem.sv
// item store: one write port, one read port with registered read data
// depends on nothing
`default_nettype none

module blal_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [31:0]       wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [31:0]       rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/blal_cmp.sv
// shared compare unit: equality and signed ordering of one stored entry
// uses blal_pkg for the flag struct
`default_nettype none

module blal_cmp (
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output blal_pkg::blal_cmp_t     flags
);

  always_comb begin
    flags.eq = (a == b);
    flags.gt = (a > b);
    flags.lt = (a < b);
  end

endmodule

`default_nettype wire

>>> hw/rtl/bounded_array_list_engine.sv
// top level: sequencer that walks the item store one entry per cycle
// uses blal_pkg, blal_mem, blal_cmp
//
// channel   signals                    beat
// req       req_valid/req_ready/req    one operation (func, value, index)
// rsp       rsp_valid/rsp_ready/rsp    one result per operation
// cfg       cfg_we/cfg_wdata           capacity limit write, no handshake
//
// steps from accept to result: peek reads the first entry, search/count/max/min read
// every entry, remove at index shifts the later entries down, remove by key searches
// then shifts down, insert shifts entries up from the rear then writes, append writes at
// the rear, rejected or unknown operations go to the result. the single store read port takes one entry a cycle.
// reset (rst, synchronous) empties the list and sets capacity to 64, no clearing pass.
// req_ready is high only while idle; a finished result waits in the rsp register.
`default_nettype none

module bounded_array_list_engine #(
  parameter int DEPTH = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire blal_pkg::blal_req_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output blal_pkg::blal_rsp_t      rsp,
  input  wire logic                cfg_we,
  input  wire logic [6:0]          cfg_wdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  blal_pkg::blal_state_t state, state_next;
  blal_pkg::blal_req_t   op, op_next;
  blal_pkg::blal_rsp_t   rsp_next;
  logic                  rsp_valid_next;
  logic [6:0]            cap;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         j, j_next;
  logic [CW-1:0]         endp, endp_next;
  logic [CW-1:0]         pa, pa_next;
  logic [CW-1:0]         posr, posr_next;
  logic [CW-1:0]         match_cnt, match_cnt_next;
  logic                  pend, pend_next;
  logic                  found, found_next;
  logic                  okf, okf_next;
  logic signed [31:0]    best, best_next;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [31:0]           mem_wdata, rdata;
  blal_pkg::blal_cmp_t   flags;
  logic signed [31:0]    cmp_b;

  logic [31:0]           eff_cap, count32, p32;
  logic [CW-1:0]         ins_pos;
  logic                  is_minmax, key_fn;

  blal_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  assign is_minmax = (op.func == blal_pkg::FN_MAX) || (op.func == blal_pkg::FN_MIN);
  assign key_fn    = (op.func == blal_pkg::FN_FIND) || (op.func == blal_pkg::FN_RMKEY) ||
                     (op.func == blal_pkg::FN_COUNT);
  assign cmp_b     = is_minmax ? best : op.value;

  blal_cmp u_cmp (
    .a     (rdata),
    .b     (cmp_b),
    .flags (flags)
  );

  assign count32 = 32'(count);
  assign eff_cap = (32'(cap) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(cap);
  assign p32     = (req.func == blal_pkg::FN_APPEND) ? count32 : 32'(req.index);
  assign ins_pos = CW'(p32);
  assign req_ready = (state == blal_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= blal_pkg::ST_IDLE;
      count     <= '0;
      cap       <= blal_pkg::CAP_RESET;
      rsp_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
      pend      <= pend_next;
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
    end
    op        <= op_next;
    rsp       <= rsp_next;
    j         <= j_next;
    endp      <= endp_next;
    pa        <= pa_next;
    posr      <= posr_next;
    match_cnt <= match_cnt_next;
    found     <= found_next;
    okf       <= okf_next;
    best      <= best_next;
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid;
    count_next     = count;
    j_next         = j;
    endp_next      = endp;
    pa_next        = pa;
    posr_next      = posr;
    match_cnt_next = match_cnt;
    pend_next      = 1'b0;
    found_next     = found;
    okf_next       = okf;
    best_next      = best;
    mem_we         = 1'b0;
    mem_waddr      = pa[AW-1:0];
    mem_wdata      = rdata;
    mem_raddr      = j[AW-1:0];

    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      blal_pkg::ST_IDLE: begin
        if (req_valid) begin
          op_next        = req;
          j_next         = '0;
          found_next     = 1'b0;
          okf_next       = 1'b0;
          match_cnt_next = '0;
          posr_next      = '0;
          best_next      = '0;
          case (req.func)
            blal_pkg::FN_APPEND, blal_pkg::FN_INSERT: begin
              if (count32 >= eff_cap || p32 > count32) begin
                state_next = blal_pkg::ST_FIN;
              end else begin
                posr_next  = ins_pos;
                j_next     = count;
                state_next = (count == ins_pos) ? blal_pkg::ST_PUT : blal_pkg::ST_UP;
              end
            end
            blal_pkg::FN_PEEK, blal_pkg::FN_FIND, blal_pkg::FN_RMKEY, blal_pkg::FN_COUNT,
            blal_pkg::FN_MAX, blal_pkg::FN_MIN: begin
              endp_next  = (req.func == blal_pkg::FN_PEEK) ? CW'(count != '0) : count;
              state_next = blal_pkg::ST_SCAN;
            end
            blal_pkg::FN_RMIDX: begin
              if (32'(req.index) < count32) begin
                posr_next  = CW'(32'(req.index));
                j_next     = CW'(32'(req.index));
                state_next = blal_pkg::ST_DN;
              end else begin
                state_next = blal_pkg::ST_FIN;
              end
            end
            default: begin
              state_next = blal_pkg::ST_FIN;
            end
          endcase
        end
      end

      blal_pkg::ST_SCAN: begin
        if (j < endp) begin
          pend_next = 1'b1;
          pa_next   = j;
          j_next    = j + 1'b1;
        end
        if (pend) begin
          if (flags.eq && !is_minmax) begin
            match_cnt_next = match_cnt + 1'b1;
            if (!found) begin
              found_next = 1'b1;
              posr_next  = pa;
            end
          end
          // first entry seeds the running max/min
          if (pa == '0 || (op.func == blal_pkg::FN_MAX && flags.gt) ||
              (op.func == blal_pkg::FN_MIN && flags.lt)) begin
            best_next = rdata;
          end
        end
        if (j >= endp && !pend) begin
          if (op.func == blal_pkg::FN_RMKEY) begin
            if (found) begin
              j_next     = posr;
              state_next = blal_pkg::ST_DN;
            end else begin
              state_next = blal_pkg::ST_FIN;
            end
          end else begin
            okf_next   = key_fn ? found : (endp != '0);
            state_next = blal_pkg::ST_FIN;
          end
        end
      end

      blal_pkg::ST_DN: begin
        if (j < count) begin
          pend_next = 1'b1;
          pa_next   = j;
          j_next    = j + 1'b1;
        end
        if (pend) begin
          if (pa == posr) begin
            best_next = rdata;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = AW'(pa - 1'b1);
          end
        end
        if (j >= count && !pend) begin
          count_next = count - 1'b1;
          okf_next   = 1'b1;
          found_next = 1'b1;
          state_next = blal_pkg::ST_FIN;
        end
      end

      blal_pkg::ST_UP: begin
        mem_raddr = AW'(j - 1'b1);
        if (j > posr) begin
          pend_next = 1'b1;
          pa_next   = j - 1'b1;
          j_next    = j - 1'b1;
        end
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(pa + 1'b1);
        end
        if (j == posr && !pend) begin
          state_next = blal_pkg::ST_PUT;
        end
      end

      blal_pkg::ST_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = posr[AW-1:0];
        mem_wdata  = op.value;
        count_next = count + 1'b1;
        okf_next   = 1'b1;
        state_next = blal_pkg::ST_FIN;
      end

      blal_pkg::ST_FIN: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_next.ok          = okf;
          rsp_next.item_value  = '0;
          rsp_next.position    = '0;
          rsp_next.match_count = '0;
          if (okf) begin
            case (op.func)
              blal_pkg::FN_PEEK, blal_pkg::FN_MAX, blal_pkg::FN_MIN,
              blal_pkg::FN_RMIDX: rsp_next.item_value = best;
              blal_pkg::FN_FIND, blal_pkg::FN_RMKEY: rsp_next.item_value = op.value;
              default: rsp_next.item_value = '0;
            endcase
            if (key_fn) begin
              rsp_next.position = 6'(posr);
            end
          end
          if (op.func == blal_pkg::FN_COUNT) begin
            rsp_next.match_count = 7'(match_cnt);
          end
          rsp_next.item_count = 7'(count);
          rsp_next.is_full    = (count32 >= eff_cap);
          rsp_next.is_empty   = (count == '0);
          rsp_valid_next      = 1'b1;
          state_next          = blal_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = blal_pkg::ST_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(DEPTH))
    else $error("item count above store depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state != blal_pkg::ST_IDLE)
    else $error("accepted request did not start the sequencer");

  a_put_grows: assert property (@(posedge clk) disable iff (rst)
    state == blal_pkg::ST_PUT |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the list");

endmodule

`default_nettype wire
